### src/jsp_pkg.sv
// Package for the JSON scalar parser: parse modes, status and kind codes,
// and the literal text table. No dependencies.
`default_nettype none
package jsp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned InTdataW = 8;
  localparam int unsigned OutTdataW = 16;

  typedef enum logic [4:0] {
    M_LEAD   = 5'd0,
    M_LIT    = 5'd1,
    M_NSIGN  = 5'd2,
    M_NZERO  = 5'd3,
    M_NINT   = 5'd4,
    M_NFRAC0 = 5'd5,
    M_NFRAC  = 5'd6,
    M_NEXP0  = 5'd7,
    M_NEXPS  = 5'd8,
    M_NEXP   = 5'd9,
    M_STR    = 5'd10,
    M_ESC    = 5'd11,
    M_AFTER  = 5'd12,
    M_TRAIL  = 5'd13,
    M_SKIP   = 5'd14
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_EXPECT       = 3'd1,
    ST_INVALID      = 3'd2,
    ST_NOT_SINGULAR = 3'd3,
    ST_BAD_ESCAPE   = 3'd4,
    ST_MISS_QUOTE   = 3'd5,
    ST_BAD_CHAR     = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    K_NULL   = 3'd0,
    K_FALSE  = 3'd1,
    K_TRUE   = 3'd2,
    K_NUMBER = 3'd3,
    K_STRING = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    LIT_NULL  = 2'd0,
    LIT_TRUE  = 2'd1,
    LIT_FALSE = 2'd2
  } lit_e;

  // literal byte at a position; select already folded to a defined code
  function automatic logic [ByteW-1:0] lit_char(input lit_e sel, input logic [2:0] pos);
    logic [ByteW-1:0] c;
    c = 8'h00;
    unique case (sel)
      LIT_TRUE: begin
        unique case (pos)
          3'd0: c = "t";
          3'd1: c = "r";
          3'd2: c = "u";
          3'd3: c = "e";
          default: c = 8'h00;
        endcase
      end
      LIT_FALSE: begin
        unique case (pos)
          3'd0: c = "f";
          3'd1: c = "a";
          3'd2: c = "l";
          3'd3: c = "s";
          3'd4: c = "e";
          default: c = 8'h00;
        endcase
      end
      default: begin
        unique case (pos)
          3'd0: c = "n";
          3'd1: c = "u";
          3'd2: c = "l";
          3'd3: c = "l";
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [2:0] lit_last(input lit_e sel);
    return (sel == LIT_FALSE) ? 3'd4 : 3'd3;
  endfunction

  function automatic kind_e lit_kind(input lit_e sel);
    kind_e k;
    unique case (sel)
      LIT_TRUE:  k = K_TRUE;
      LIT_FALSE: k = K_FALSE;
      default:   k = K_NULL;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

### src/json_scalar_parser.sv
// JSON scalar root parser, top level.
// Depends on jsp_pkg.
`default_nettype none
// Takes one text byte per word on the slave side, a zero byte ending each
// text, and checks that the text is a single JSON scalar (null, true, false,
// a number or a string) with optional whitespace around it. Decoded string
// bytes come out as words with tuser set; the verdict comes out as one word
// with tlast set, carrying status and value kind. After an error the bytes
// up to and including the next zero byte are dropped. One byte is taken
// every cycle unless a held output word stalls it: the whole parse step is a
// single state update in the cycle the byte is accepted, and the output
// register frees the input side whenever its word is taken in the same cycle.
module json_scalar_parser
  import jsp_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [InTdataW-1:0]  s_axis_tdata,   // [7:0] text_byte
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [OutTdataW-1:0]      m_axis_tdata,   // [7:0] out_char, [10:8] status,
                                                    // [13:11] value_kind, [15:14] zero
  output logic                      m_axis_tuser,   // char_valid
  output logic                      m_axis_tlast    // done_res
);

  mode_e            mode_q, mode_d;
  lit_e             sel_q, sel_d;
  logic [2:0]       pos_q, pos_d;
  kind_e            kind_q, kind_d;

  logic             ovalid_q;
  logic [ByteW-1:0] ochar_q;
  logic             ocv_q, odone_q;
  status_e          ost_q;
  kind_e            okind_q;

  logic             in_acc, out_acc;
  logic [ByteW-1:0] b;
  logic             b_zero, b_space, b_digit;
  logic             emit, fin;
  logic [ByteW-1:0] emit_ch;
  status_e          fin_st;
  lit_e             sel_eff;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = !ovalid_q || m_axis_tready;

  assign b       = s_axis_tdata[ByteW-1:0];
  assign b_zero  = (b == 8'h00);
  assign b_space = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);
  assign b_digit = (b >= "0") && (b <= "9");
  assign sel_eff = (sel_q == LIT_NULL || sel_q == LIT_TRUE || sel_q == LIT_FALSE)
                   ? sel_q : LIT_NULL;

  always_comb begin
    mode_d  = mode_q;
    sel_d   = sel_q;
    pos_d   = pos_q;
    kind_d  = kind_q;
    emit    = 1'b0;
    emit_ch = b;
    fin     = 1'b0;
    fin_st  = ST_OK;
    unique case (mode_q)
      M_LEAD: begin
        if (b_space) begin
        end else if (b_zero) begin
          fin = 1'b1; fin_st = ST_EXPECT;
        end else if (b == "n" || b == "t" || b == "f") begin
          sel_d  = (b == "n") ? LIT_NULL : (b == "t") ? LIT_TRUE : LIT_FALSE;
          pos_d  = 3'd1;
          kind_d = lit_kind(sel_d);
          mode_d = M_LIT;
        end else if (b == "-" || b_digit) begin
          kind_d = K_NUMBER;
          mode_d = (b == "-") ? M_NSIGN : (b == "0") ? M_NZERO : M_NINT;
        end else if (b == "\"") begin
          kind_d = K_STRING;
          mode_d = M_STR;
        end else begin
          fin = 1'b1; fin_st = ST_INVALID;
        end
      end
      M_LIT: begin
        if (pos_q > lit_last(sel_eff) || b != lit_char(sel_eff, pos_q)) begin
          fin = 1'b1; fin_st = ST_INVALID;
        end else begin
          kind_d = lit_kind(sel_eff);
          pos_d  = pos_q + 3'd1;
          if (pos_q == lit_last(sel_eff)) mode_d = M_AFTER;
        end
      end
      M_NSIGN: begin
        if (!b_digit) begin
          fin = 1'b1; fin_st = ST_INVALID;
        end else begin
          mode_d = (b == "0") ? M_NZERO : M_NINT;
        end
      end
      M_NZERO, M_NINT, M_NFRAC, M_NEXP: begin
        if (b_digit && mode_q != M_NZERO) begin
        end else if (b == "." && (mode_q == M_NZERO || mode_q == M_NINT)) begin
          mode_d = M_NFRAC0;
        end else if ((b == "e" || b == "E") && mode_q != M_NEXP) begin
          mode_d = M_NEXP0;
        end else if (b_zero) begin
          fin = 1'b1; fin_st = ST_OK;
        end else if (b_space) begin
          mode_d = M_TRAIL;
        end else begin
          fin = 1'b1; fin_st = ST_INVALID;
        end
      end
      M_NFRAC0: begin
        if (!b_digit) begin
          fin = 1'b1; fin_st = ST_INVALID;
        end else begin
          mode_d = M_NFRAC;
        end
      end
      M_NEXP0: begin
        if (b == "+" || b == "-") begin
          mode_d = M_NEXPS;
        end else if (b_digit) begin
          mode_d = M_NEXP;
        end else begin
          fin = 1'b1; fin_st = ST_INVALID;
        end
      end
      M_NEXPS: begin
        if (!b_digit) begin
          fin = 1'b1; fin_st = ST_INVALID;
        end else begin
          mode_d = M_NEXP;
        end
      end
      M_STR: begin
        if (b == "\"") begin
          mode_d = M_AFTER;
        end else if (b == "\\") begin
          mode_d = M_ESC;
        end else if (b_zero) begin
          fin = 1'b1; fin_st = ST_MISS_QUOTE;
        end else if (b < 8'h20) begin
          fin = 1'b1; fin_st = ST_BAD_CHAR;
        end else begin
          emit = 1'b1;
        end
      end
      M_ESC: begin
        mode_d = M_STR;
        emit   = 1'b1;
        unique case (b)
          "\"", "\\", "/": emit_ch = b;
          "b": emit_ch = 8'h08;
          "f": emit_ch = 8'h0c;
          "n": emit_ch = 8'h0a;
          "r": emit_ch = 8'h0d;
          "t": emit_ch = 8'h09;
          default: begin
            emit = 1'b0;
            fin  = 1'b1; fin_st = ST_BAD_ESCAPE;
          end
        endcase
      end
      M_AFTER: begin
        if (b_zero) begin
          fin = 1'b1; fin_st = ST_OK;
        end else if (b_space) begin
          mode_d = M_TRAIL;
        end else begin
          fin = 1'b1; fin_st = ST_INVALID;
        end
      end
      M_TRAIL: begin
        if (b_space) begin
        end else if (b_zero) begin
          fin = 1'b1; fin_st = ST_OK;
        end else begin
          fin = 1'b1; fin_st = ST_NOT_SINGULAR;
        end
      end
      default: begin
        // skip to end of text; unused codes behave the same
        if (b_zero) begin
          mode_d = M_LEAD;
          sel_d  = LIT_NULL;
          pos_d  = 3'd0;
          kind_d = K_NULL;
        end
      end
    endcase
    if (fin) begin
      mode_d = (fin_st == ST_OK || b_zero) ? M_LEAD : M_SKIP;
      sel_d  = LIT_NULL;
      pos_d  = 3'd0;
      kind_d = K_NULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_LEAD;
      sel_q    <= LIT_NULL;
      pos_q    <= 3'd0;
      kind_q   <= K_NULL;
      ovalid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        mode_q   <= mode_d;
        sel_q    <= sel_d;
        pos_q    <= pos_d;
        kind_q   <= kind_d;
        ovalid_q <= emit || fin;
      end else if (out_acc) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (emit || fin)) begin
      ochar_q <= emit ? emit_ch : 8'h00;
      ocv_q   <= emit;
      odone_q <= fin;
      ost_q   <= fin ? fin_st : ST_OK;
      okind_q <= (fin && fin_st == ST_OK) ? kind_q : K_NULL;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {2'b00, okind_q, ost_q, ochar_q};
  assign m_axis_tuser  = ocv_q;
  assign m_axis_tlast  = odone_q;

endmodule
`default_nettype wire

### src/jsp_checker.sv
// Port-level checks for the JSON scalar parser, bound to the top level.
// Depends on jsp_pkg and json_scalar_parser.
`default_nettype none
module jsp_checker
  import jsp_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tready,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [OutTdataW-1:0] m_axis_tdata,
  input wire logic                 m_axis_tuser,
  input wire logic                 m_axis_tlast
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser != m_axis_tlast))
    else $error("word is neither or both char and verdict");

  a_char_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[15:8] == 8'h00)
    else $error("char word carries status or kind");

  a_err_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast && m_axis_tdata[10:8] != ST_OK
      |-> m_axis_tdata[13:11] == K_NULL && m_axis_tdata[7:0] == 8'h00)
    else $error("error verdict with nonzero kind or char");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

endmodule

bind json_scalar_parser jsp_checker u_jsp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
